>>> design/chi_pkg.sv
package chi_pkg;

    localparam int BUCKETS_DEF      = 1009;
    localparam int POOL_ENTRIES_DEF = 1024;

    localparam int KEY_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_handle;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture request, start bucket mod
        logic mod_step;    // one step of the bucket reduction
        logic rd_head;     // read bucket head memory
        logic take_head;   // current = head
        logic rd_entry;    // read entry at current
        logic advance;     // prev = cur, cur = link
        logic do_insert;   // write new entry and head
        logic do_remove;   // unlink current
        logic clr_step;    // clear one bucket head row
        logic set_rsp;     // latch response
        logic [STATUS_W-1:0] rsp_status;
        logic rsp_hit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic cur_ok;      // current pointer valid and in range
        logic key_match;
        logic walk_limit;
        logic can_alloc;
        logic clr_done;
    } t_sts;

endpackage

>>> design/chi_if.sv
interface chi_req_if;
    import chi_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface chi_rsp_if;
    import chi_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/chi_datapath.sv
module chi_datapath #(
    parameter int BUCKETS      = chi_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = chi_pkg::POOL_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chi_pkg::t_req  i_req,
    input  chi_pkg::t_cmd  i_cmd,
    output chi_pkg::t_sts  o_sts,
    output chi_pkg::t_rsp  o_rsp
);
    import chi_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam int MW = KEY_W + 1;
    localparam int RS = KEY_W + $clog2(BUCKETS);
    localparam logic [MW-1:0]    RECIP = MW'((64'd1 << RS) / 64'(BUCKETS));
    localparam logic [KEY_W-1:0] BMOD  = KEY_W'(BUCKETS);

    // head and link rows hold {valid, ptr}
    logic [PW:0]         m_head [BUCKETS];
    logic [KEY_W-1:0]    m_key  [POOL_ENTRIES];
    logic [HANDLE_W-1:0] m_hdl  [POOL_ENTRIES];
    logic [PW:0]         m_link [POOL_ENTRIES];

    t_req            r_req;
    logic [KEY_W-1:0] r_quo;
    logic [KEY_W-1:0] r_rem;
    logic [1:0]      r_sh;
    logic [BW-1:0]   r_clr;
    logic [BW-1:0]   r_bkt;
    logic [PW-1:0]   r_head_rd;
    logic            r_head_ok;
    logic [PW-1:0]   r_cur, r_prev;
    logic            r_cur_ok, r_prev_ok;
    logic [KEY_W-1:0]    r_ekey;
    logic [HANDLE_W-1:0] r_ehdl;
    logic [PW-1:0]       r_elink;
    logic                r_elink_ok;
    logic [CW-1:0]   r_steps;
    logic [CW-1:0]   r_unused;
    logic [PW-1:0]   r_free;
    logic            r_free_ok;
    t_rsp            r_rsp;

    // key mod BUCKETS: reciprocal estimate of the quotient, multiply back,
    // then one correction since the estimate is low by at most one
    logic [KEY_W+MW-1:0] w_prod;
    logic [KEY_W-1:0]    w_qd;
    logic [KEY_W-1:0]    w_fix;
    assign w_prod = {{MW{1'b0}}, r_req.key} * {{KEY_W{1'b0}}, RECIP};
    assign w_qd   = r_quo * BMOD;
    assign w_fix  = (r_rem >= BMOD) ? r_rem - BMOD : r_rem;

    logic          w_use_free;
    logic [PW-1:0] w_new;
    assign w_use_free = r_free_ok && (CW'(r_free) < CW'(POOL_ENTRIES));
    assign w_new = w_use_free ? r_free : r_unused[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_sh  <= 2'd2;
        end else if (i_cmd.mod_step) begin
            if (r_sh == 2'd2) r_quo <= KEY_W'(w_prod >> RS);
            else if (r_sh == 2'd1) r_rem <= r_req.key - w_qd;
            else r_rem <= w_fix;
            if (r_sh != '0) r_sh <= r_sh - 1'b1;
        end
        if (i_cmd.rd_head) begin
            r_bkt                  <= r_rem[BW-1:0];
            {r_head_ok, r_head_rd} <= m_head[r_rem[BW-1:0]];
        end
        if (i_cmd.rd_entry) begin
            r_ekey                <= m_key[r_cur];
            r_ehdl                <= m_hdl[r_cur];
            {r_elink_ok, r_elink} <= m_link[r_cur];
        end
        if (i_cmd.clr_step) begin
            m_head[r_clr] <= '0;
        end
        if (i_cmd.do_insert) begin
            m_key[w_new]  <= r_req.key;
            m_hdl[w_new]  <= r_req.handle;
            m_link[w_new] <= {r_head_ok, r_head_rd};
            m_head[r_bkt] <= {1'b1, w_new};
        end
        if (i_cmd.do_remove) begin
            m_link[r_cur] <= {r_free_ok, r_free};
            if (r_prev_ok) m_link[r_prev] <= {r_elink_ok, r_elink};
            else m_head[r_bkt] <= {r_elink_ok, r_elink};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_unused  <= '0;
            r_free    <= '0;
            r_free_ok <= 1'b0;
            r_cur_ok  <= 1'b0;
            r_prev_ok <= 1'b0;
            r_steps   <= '0;
            r_rsp     <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.take_head) begin
                r_cur     <= r_head_rd;
                r_cur_ok  <= r_head_ok;
                r_prev_ok <= 1'b0;
                r_steps   <= '0;
            end else if (i_cmd.advance) begin
                r_prev    <= r_cur;
                r_prev_ok <= 1'b1;
                r_cur     <= r_elink;
                r_cur_ok  <= r_elink_ok;
                r_steps   <= r_steps + 1'b1;
            end
            if (i_cmd.do_insert) begin
                if (w_use_free) begin
                    {r_free_ok, r_free} <= m_link[r_free];
                end else begin
                    r_unused <= r_unused + 1'b1;
                end
            end
            if (i_cmd.do_remove) begin
                r_free    <= r_cur;
                r_free_ok <= 1'b1;
            end
            if (i_cmd.set_rsp) begin
                r_rsp.status       <= i_cmd.rsp_status;
                r_rsp.found_handle <= i_cmd.rsp_hit ? r_ehdl : '0;
            end
        end
    end

    assign o_sts.mod_done   = (r_sh == '0);
    assign o_sts.cur_ok     = r_cur_ok && (CW'(r_cur) < CW'(POOL_ENTRIES));
    assign o_sts.key_match  = (r_ekey == r_req.key);
    assign o_sts.walk_limit = (r_steps >= CW'(POOL_ENTRIES));
    assign o_sts.can_alloc  = w_use_free || (r_unused < CW'(POOL_ENTRIES));
    assign o_sts.clr_done   = (r_clr == BW'(BUCKETS - 1));
    assign o_rsp = r_rsp;

endmodule

>>> design/chi_ctrl.sv
module chi_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic [chi_pkg::FUNC_W-1:0] i_func,
    output logic                       o_req_ready,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    input  chi_pkg::t_sts              i_sts,
    output chi_pkg::t_cmd              o_cmd
);
    import chi_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_TAKE  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_INS   = 3'd6;
    localparam logic [2:0] S_CLR   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [FUNC_W-1:0] r_func;
    logic              r_rsp_valid, n_rsp_valid;

    // a new item may enter once the previous beat's result slot is free
    assign o_req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state = S_TAKE;
            end
            S_TAKE: begin
                if (r_func == FUNC_INSERT) begin
                    n_state = S_INS;
                end else if (r_func == FUNC_LOOKUP || r_func == FUNC_REMOVE) begin
                    o_cmd.take_head = 1'b1;
                    n_state = S_READ;
                end else begin
                    o_cmd.set_rsp = 1'b1;
                    o_cmd.rsp_status = STATUS_NOT_FOUND;
                    n_rsp_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (i_sts.cur_ok && !i_sts.walk_limit) begin
                    o_cmd.rd_entry = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.set_rsp = 1'b1;
                    o_cmd.rsp_status = STATUS_NOT_FOUND;
                    n_rsp_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.key_match) begin
                    o_cmd.set_rsp = 1'b1;
                    o_cmd.rsp_status = STATUS_DONE;
                    o_cmd.rsp_hit = (r_func == FUNC_LOOKUP);
                    o_cmd.do_remove = (r_func == FUNC_REMOVE);
                    n_rsp_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_READ;
                end
            end
            S_INS: begin
                o_cmd.set_rsp = 1'b1;
                n_rsp_valid = 1'b1;
                n_state = S_IDLE;
                if (i_sts.can_alloc) begin
                    o_cmd.do_insert = 1'b1;
                    o_cmd.rsp_status = STATUS_DONE;
                end else begin
                    o_cmd.rsp_status = STATUS_FULL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_rsp_valid <= 1'b0;
            r_func      <= FUNC_LOOKUP;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            if (o_cmd.load) r_func <= i_func;
        end
    end

endmodule

>>> design/chained_hash_index.sv
// Hash index with separate chaining over a fixed entry pool. Each request beat
// carries func (lookup, insert, remove), key and handle, and gives exactly one
// response beat with status and found_handle. After reset the block clears one
// bucket head per cycle, for all BUCKETS heads (1009 by default), and takes no
// request until that is done. The bucket is key mod BUCKETS, found by a
// reciprocal quotient estimate, a multiply back and one correction; then the
// bucket head is read and the operation decoded. On a lookup or remove, each
// entry walked on the chain takes a read and a compare state. One item is in
// flight at a time; the result waits in an output register and the next
// request is accepted no earlier than the cycle in which that result is taken.
module chained_hash_index #(
    parameter int BUCKETS      = chi_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = chi_pkg::POOL_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chi_req_if.sink   i_req,
    chi_rsp_if.source o_rsp
);
    import chi_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    chi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_func      (i_req.data.func),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    chi_datapath #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp.data)
    );

endmodule
